### hw/rtl/cps_pkg.sv
// Package holding the types, state codes and constants of the coverage path sequencer.
package cps_pkg;

    localparam int SPEED_BITS = 10;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;
    localparam logic [11:0] TILT_LIMIT = 12'd900;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [4:0] {
        ST_WAIT   = 5'd0,
        ST_FL     = 5'd1,
        ST_FL_D   = 5'd2,
        ST_DL     = 5'd3,
        ST_DL_D   = 5'd4,
        ST_REV    = 5'd5,
        ST_REV_D  = 5'd6,
        ST_FU     = 5'd7,
        ST_FU_D   = 5'd8,
        ST_UD     = 5'd9,
        ST_UD_D   = 5'd10,
        ST_REV1   = 5'd11,
        ST_REV1_D = 5'd12,
        ST_FR     = 5'd13,
        ST_FR_D   = 5'd14,
        ST_DR     = 5'd15,
        ST_DR_D   = 5'd16,
        ST_FD     = 5'd17,
        ST_FD_D   = 5'd18,
        ST_FL1    = 5'd19,
        ST_FL1_D  = 5'd20,
        ST_DL1    = 5'd21,
        ST_DL1_D  = 5'd22,
        ST_NONE   = 5'd24
    } t_state;

    typedef enum logic [2:0] {
        D_STOP = 3'd0,
        D_FWD  = 3'd1,
        D_REV  = 3'd2,
        D_CW   = 3'd3,
        D_CCW  = 3'd4
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE_MS      = 3'd0,
        CFG_TILT_TOLERANCE = 3'd1,
        CFG_TILT_GAIN      = 3'd2,
        CFG_TURN_SPEED     = 3'd3,
        CFG_SIDE_SPEED     = 3'd4,
        CFG_UP_SPEED       = 3'd5,
        CFG_DOWN_SPEED     = 3'd6,
        CFG_LEG_DISTANCE   = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_SETTLE_MS      = 16'd500;
    localparam logic [9:0]  RST_TILT_TOLERANCE = 10'd50;
    localparam logic [15:0] RST_TILT_GAIN      = 16'd256;
    localparam logic [9:0]  RST_TURN_SPEED     = 10'd300;
    localparam logic [9:0]  RST_SIDE_SPEED     = 10'd300;
    localparam logic [9:0]  RST_UP_SPEED       = 10'd400;
    localparam logic [9:0]  RST_DOWN_SPEED     = 10'd200;
    localparam logic [15:0] RST_LEG_DISTANCE   = 16'd200;

endpackage

### hw/rtl/coverage_path_sequencer_top.sv
// Top level of the coverage path sequencer: tick register, pattern state machine, command register.
// The sequencer takes one control tick per clock cycle unless a low i_out_ready stalls the output
// register, and returns one command beat per tick: the tick is registered, the pattern state
// machine, the single steering multiplier and the saturation decide the command combinationally,
// and the result lands in an output register. The pattern state is updated at the same edge, so
// the next tick, already waiting in the tick register, sees it. Configuration is written through
// a plain write port while no tick is in flight; the user must ensure this, the block does not.
// Steering speeds are base plus or minus tilt times gain in Q8.8, floored and saturated to the
// speed range; after every stop, later ticks are held until the settle time since state entry passes.
module coverage_path_sequencer_top
    import cps_pkg::*;
#(
    parameter int REVERSE_MM = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_bumper_pressed,
    input  logic                  i_x_tilt_valid,
    input  logic signed [11:0]    i_x_tilt,
    input  logic                  i_x_tilt_up,
    input  logic                  i_y_tilt_valid,
    input  logic signed [11:0]    i_y_tilt,
    input  logic                  i_y_tilt_up,
    input  logic [15:0]           i_left_distance,
    input  logic [15:0]           i_right_distance,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_drive_valid,
    output logic [9:0]            o_left_speed,
    output logic [9:0]            o_right_speed,
    output logic [2:0]            o_drive_dir,
    output logic                  o_reset_distance,
    output logic [4:0]            o_current_state,
    output logic                  o_held
);

    logic [15:0] r_settle_ms;
    logic [9:0]  r_tilt_tolerance;
    logic [15:0] r_tilt_gain;
    logic [9:0]  r_turn_speed;
    logic [9:0]  r_side_speed;
    logic [9:0]  r_up_speed;
    logic [9:0]  r_down_speed;
    logic [15:0] r_leg_distance;

    logic               r_in_valid;
    logic [31:0]        r_now_ms;
    logic               r_bump;
    logic               r_xv;
    logic signed [11:0] r_x;
    logic               r_xup;
    logic               r_yv;
    logic signed [11:0] r_y;
    logic               r_yup;
    logic [15:0]        r_ld;
    logic [15:0]        r_rd;

    t_state      r_state, n_state;
    t_state      r_prev;
    logic [31:0] r_start_ms;
    logic        r_settle_pending, n_settle_pending;
    logic        r_turn_left, n_turn_left;

    logic        r_out_valid;
    logic        r_drive_valid;
    logic [9:0]  r_left_speed;
    logic [9:0]  r_right_speed;
    t_dir        r_drive_dir;
    logic        r_reset_distance;
    logic [4:0]  r_current_state;
    logic        r_held;

    logic        adv;
    logic        held;
    logic [31:0] elapsed;

    logic        cmd_valid;
    logic [9:0]  cmd_l;
    logic [9:0]  cmd_r;
    t_dir        cmd_d;

    logic signed [12:0] x_ext;
    logic signed [12:0] tol_s;
    logic [11:0]        mag_x;
    logic [11:0]        mag_y;
    logic               ysteer;
    logic               c_face_left;
    logic               c_face_right;
    logic               c_face_up;
    logic               c_face_down;
    logic               c_rev_done;
    logic               c_leg_done;

    logic [9:0]         st_base;
    logic signed [11:0] st_tilt;
    logic               st_neg;
    logic signed [16:0] st_gain;
    logic signed [28:0] st_prod;
    logic signed [29:0] st_term;
    logic signed [29:0] st_sum;
    logic [21:0]        st_quot;
    logic [9:0]         sv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms      <= RST_SETTLE_MS;
            r_tilt_tolerance <= RST_TILT_TOLERANCE;
            r_tilt_gain      <= RST_TILT_GAIN;
            r_turn_speed     <= RST_TURN_SPEED;
            r_side_speed     <= RST_SIDE_SPEED;
            r_up_speed       <= RST_UP_SPEED;
            r_down_speed     <= RST_DOWN_SPEED;
            r_leg_distance   <= RST_LEG_DISTANCE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SETTLE_MS:      r_settle_ms      <= i_cfg_data;
                CFG_TILT_TOLERANCE: r_tilt_tolerance <= i_cfg_data[9:0];
                CFG_TILT_GAIN:      r_tilt_gain      <= i_cfg_data;
                CFG_TURN_SPEED:     r_turn_speed     <= i_cfg_data[9:0];
                CFG_SIDE_SPEED:     r_side_speed     <= i_cfg_data[9:0];
                CFG_UP_SPEED:       r_up_speed       <= i_cfg_data[9:0];
                CFG_DOWN_SPEED:     r_down_speed     <= i_cfg_data[9:0];
                CFG_LEG_DISTANCE:   r_leg_distance   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_now_ms <= i_now_ms;
            r_bump   <= i_bumper_pressed;
            r_xv     <= i_x_tilt_valid;
            r_x      <= i_x_tilt;
            r_xup    <= i_x_tilt_up;
            r_yv     <= i_y_tilt_valid;
            r_y      <= i_y_tilt;
            r_yup    <= i_y_tilt_up;
            r_ld     <= i_left_distance;
            r_rd     <= i_right_distance;
        end
    end

    assign elapsed = r_now_ms - r_start_ms;
    assign held    = r_settle_pending && (elapsed < {16'd0, r_settle_ms});

    assign x_ext  = {r_x[11], r_x};
    assign tol_s  = $signed({3'd0, r_tilt_tolerance});
    assign mag_x  = r_x[11] ? 12'(-r_x) : r_x;
    assign mag_y  = r_y[11] ? 12'(-r_y) : r_y;
    assign ysteer = r_yv && (mag_y < TILT_LIMIT);

    assign c_face_left  = r_xv && (x_ext < (tol_s - $signed({1'b0, TILT_LIMIT})));
    assign c_face_right = r_xv && (x_ext > ($signed({1'b0, TILT_LIMIT}) - tol_s));
    assign c_face_up    = r_xv && r_xup && ({1'b0, mag_x} < {3'd0, r_tilt_tolerance});
    assign c_face_down  = r_xv && !r_xup && (x_ext < tol_s);
    assign c_rev_done   = (r_ld > 16'(REVERSE_MM)) && (r_rd > 16'(REVERSE_MM));
    assign c_leg_done   = (r_ld > r_leg_distance) && (r_rd > r_leg_distance);

    always_comb begin
        st_base = r_side_speed;
        st_tilt = r_y;
        st_neg  = 1'b0;
        case (r_state)
            ST_DL:  st_neg = r_yup;
            ST_DR:  st_neg = r_yup;
            ST_DL1: st_neg = !r_yup;
            ST_UD: begin
                st_tilt = r_x;
                st_neg  = r_x[11];
                st_base = (r_prev == ST_FU_D) ? r_up_speed : r_down_speed;
            end
            default: ;
        endcase
    end

    assign st_gain = $signed({1'b0, r_tilt_gain});
    assign st_prod = st_tilt * st_gain;
    assign st_term = st_neg ? -{st_prod[28], st_prod} : {st_prod[28], st_prod};
    assign st_sum  = $signed({12'd0, st_base, 8'd0}) + st_term;
    assign st_quot = st_sum[29:8];

    always_comb begin
        if (st_sum[29]) begin
            sv = '0;
        end else if (st_quot > 22'(SPEED_MAX)) begin
            sv = SPEED_MAX;
        end else begin
            sv = st_quot[9:0];
        end
    end

    // Next pattern state, settle flag and turn side.
    always_comb begin
        n_state          = r_state;
        n_settle_pending = r_settle_pending;
        n_turn_left      = r_turn_left;
        if (!held) begin
            case (r_state)
                ST_WAIT: begin
                    if (r_bump) n_state = ST_FL;
                end
                ST_FL: begin
                    if (c_face_left) begin
                        n_state          = ST_FL_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_FL_D, ST_FU_D, ST_FD_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = (r_state == ST_FL_D) ? ST_DL : ST_UD;
                end
                ST_DL: begin
                    if (r_bump) begin
                        n_state          = ST_DL_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_DL_D, ST_UD_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = (r_state == ST_DL_D) ? ST_REV : ST_REV1;
                end
                ST_REV, ST_REV1: begin
                    if (c_rev_done) begin
                        n_state          = (r_state == ST_REV) ? ST_REV_D : ST_REV1_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_REV_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = ST_FU;
                end
                ST_FU: begin
                    if (c_face_up) begin
                        n_state          = ST_FU_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_UD: begin
                    if (r_bump) begin
                        if (r_prev == ST_FU_D) n_turn_left = 1'b0;
                        if (r_prev == ST_FD_D) n_turn_left = 1'b1;
                        n_state          = ST_UD_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_REV1_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = r_turn_left ? ST_FL1 : ST_FR;
                end
                ST_FR, ST_FL1: begin
                    if (c_face_right) begin
                        n_state          = (r_state == ST_FR) ? ST_FR_D : ST_FL1_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_FR_D, ST_FL1_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = (r_state == ST_FR_D) ? ST_DR : ST_DL1;
                end
                ST_DR, ST_DL1: begin
                    if (c_leg_done) begin
                        n_state          = (r_state == ST_DR) ? ST_DR_D : ST_DL1_D;
                        n_settle_pending = 1'b1;
                    end
                end
                ST_DR_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = ST_FD;
                end
                ST_DL1_D: begin
                    n_settle_pending = 1'b0;
                    n_state          = ST_FU;
                end
                ST_FD: begin
                    if (c_face_down) begin
                        n_state          = ST_FD_D;
                        n_settle_pending = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Motor command; a later assignment overrides an earlier one, so a stop wins.
    always_comb begin
        cmd_valid = 1'b0;
        cmd_l     = '0;
        cmd_r     = '0;
        cmd_d     = D_STOP;
        if (!held) begin
            case (r_state)
                ST_WAIT: begin
                    if (r_bump) begin
                        cmd_valid = 1'b1;
                        cmd_l     = r_turn_speed;
                        cmd_r     = r_turn_speed;
                        cmd_d     = D_CCW;
                    end
                end
                ST_FL, ST_FL1: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = D_CCW;
                end
                ST_FR, ST_FD, ST_REV_D, ST_DR_D: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = D_CW;
                end
                ST_DL1_D: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = D_CCW;
                end
                ST_FL_D, ST_FU_D, ST_FD_D, ST_FR_D, ST_FL1_D: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = D_FWD;
                end
                ST_DL_D, ST_UD_D, ST_REV, ST_REV1: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = D_REV;
                end
                ST_REV1_D: begin
                    cmd_valid = 1'b1;
                    cmd_l     = r_turn_speed;
                    cmd_r     = r_turn_speed;
                    cmd_d     = r_turn_left ? D_CCW : D_CW;
                end
                ST_FU: begin
                    if (r_prev == ST_REV_D || r_prev == ST_DL1_D) begin
                        cmd_valid = 1'b1;
                        cmd_l     = r_turn_speed;
                        cmd_r     = r_turn_speed;
                        cmd_d     = (r_prev == ST_REV_D) ? D_CW : D_CCW;
                    end
                end
                ST_DL, ST_DL1: begin
                    if (ysteer) begin
                        cmd_valid = 1'b1;
                        cmd_d     = D_FWD;
                        cmd_l     = r_yup ? sv : r_side_speed;
                        cmd_r     = r_yup ? r_side_speed : sv;
                    end
                end
                ST_DR: begin
                    if (ysteer) begin
                        cmd_valid = 1'b1;
                        cmd_d     = D_FWD;
                        cmd_l     = r_yup ? r_side_speed : sv;
                        cmd_r     = r_yup ? sv : r_side_speed;
                    end
                end
                ST_UD: begin
                    if (r_xv && r_x != 12'sd0 &&
                        (r_prev == ST_FU_D || r_prev == ST_FD_D)) begin
                        cmd_valid = 1'b1;
                        cmd_d     = D_FWD;
                        if ((r_prev == ST_FU_D) != r_x[11]) begin
                            cmd_l = sv;
                            cmd_r = st_base;
                        end else begin
                            cmd_l = st_base;
                            cmd_r = sv;
                        end
                    end
                end
                default: ;
            endcase

            if ((r_state == ST_FL && c_face_left) ||
                ((r_state == ST_DL || r_state == ST_UD) && r_bump) ||
                ((r_state == ST_REV || r_state == ST_REV1) && c_rev_done) ||
                (r_state == ST_FU && c_face_up) ||
                ((r_state == ST_FR || r_state == ST_FL1) && c_face_right) ||
                ((r_state == ST_DR || r_state == ST_DL1) && c_leg_done) ||
                (r_state == ST_FD && c_face_down)) begin
                cmd_valid = 1'b1;
                cmd_l     = '0;
                cmd_r     = '0;
                cmd_d     = D_STOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_WAIT;
            r_prev           <= ST_NONE;
            r_start_ms       <= '0;
            r_settle_pending <= 1'b0;
            r_turn_left      <= 1'b0;
        end else if (adv) begin
            r_state          <= n_state;
            r_settle_pending <= n_settle_pending;
            r_turn_left      <= n_turn_left;
            if (n_state != r_state) begin
                r_prev     <= r_state;
                r_start_ms <= r_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drive_valid    <= cmd_valid;
            r_left_speed     <= cmd_l;
            r_right_speed    <= cmd_r;
            r_drive_dir      <= cmd_d;
            r_reset_distance <= (n_state != r_state);
            r_current_state  <= n_state;
            r_held           <= held;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_valid    = r_drive_valid;
    assign o_left_speed     = r_left_speed;
    assign o_right_speed    = r_right_speed;
    assign o_drive_dir      = r_drive_dir;
    assign o_reset_distance = r_reset_distance;
    assign o_current_state  = r_current_state;
    assign o_held           = r_held;

    a_held_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_held |-> !o_drive_valid && !o_reset_distance)
        else $error("held beat carries a command or a state change");

    a_change_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_distance |-> o_drive_valid)
        else $error("state change without a motor command");

    a_settle_in_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle_pending |-> !r_state[0] && r_state != ST_WAIT)
        else $error("settle pending outside a stopped state");

    a_stop_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_dir == D_STOP |-> o_left_speed == '0 && o_right_speed == '0)
        else $error("stop beat with non-zero speed");

endmodule
